>>> hdl/assert_macros.svh
// Assertion macros for the key search core.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hdl/aesks_pkg.sv
// Package for the AES-128 key search core: types, S-box, round helpers.
// No dependencies.
`default_nettype none
package aesks_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned IdxW = 2;
  localparam logic [IdxW-1:0] RegPtHi = 2'd0;
  localparam logic [IdxW-1:0] RegPtLo = 2'd1;
  localparam logic [IdxW-1:0] RegTgHi = 2'd2;
  localparam logic [IdxW-1:0] RegTgLo = 2'd3;

  typedef logic [127:0] blk_t;

  // side info that travels with each item
  typedef struct packed {
    logic         stop;
    logic         last_key;
    logic [127:0] key;
  } tag_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_b(input blk_t b, input int unsigned i);
    get_b = b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t next_rk(input blk_t rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96]; w1 = rk[95:64]; w2 = rk[63:32]; w3 = rk[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  function automatic blk_t enc_round(input blk_t s, input blk_t rk, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = SBOX[get_b(s, r + 4*((c + r) % 4))];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    enc_round = o ^ rk;
  endfunction
endpackage
`default_nettype wire

>>> hdl/aesks_round.sv
// One pipeline stage: one AES round plus the matching key schedule step.
// Depends on aesks_pkg.
`default_nettype none
module aesks_round (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic [7:0]           rcon_i,
  input  wire logic                 mix_i,
  input  wire logic                 vld_i,
  input  wire aesks_pkg::blk_t      st_i,
  input  wire aesks_pkg::blk_t      rk_i,
  input  wire aesks_pkg::tag_t      tag_i,
  output logic                      vld_o,
  output aesks_pkg::blk_t           st_o,
  output aesks_pkg::blk_t           rk_o,
  output aesks_pkg::tag_t           tag_o
);
  logic            vld_q;
  aesks_pkg::blk_t st_q, st_d, rk_q, rk_d;
  aesks_pkg::tag_t tag_q;

  always_comb begin
    rk_d = aesks_pkg::next_rk(rk_i, rcon_i);
    st_d = aesks_pkg::enc_round(st_i, rk_d, mix_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q  <= st_d;
      rk_q  <= rk_d;
      tag_q <= tag_i;
    end
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;
  assign rk_o  = rk_q;
  assign tag_o = tag_q;
endmodule
`default_nettype wire

>>> hdl/aesks_tally.sv
// Final stage: ciphertext compare, run counter, output register.
// Depends on aesks_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aesks_tally (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire logic                 take_i,
  input  wire logic                 vld_i,
  input  wire aesks_pkg::blk_t      ct_i,
  input  wire aesks_pkg::blk_t      target_i,
  input  wire aesks_pkg::tag_t      tag_i,
  output logic                      vld_o,
  output logic                      match_o,
  output logic                      done_res_o,
  output logic [127:0]              found_key_o,
  output logic [63:0]               key_count_o
);
  logic          vld_q, match_q, done_q;
  logic [127:0]  found_q;
  logic [63:0]   tried_q, tried_d, cnt_q, cnt_d, inc;
  logic          hit, load;

  assign load = adv_i && vld_i;
  assign inc  = (cnt_q == '1) ? cnt_q : cnt_q + 64'd1;

  always_comb begin
    hit     = !tag_i.stop && (ct_i == target_i);
    tried_d = tag_i.stop ? cnt_q : inc;
    cnt_d   = (tag_i.stop || hit || tag_i.last_key) ? 64'd0 : inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (adv_i) vld_q <= vld_i;
      else if (take_i) vld_q <= 1'b0;
      if (load) cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      match_q <= hit;
      done_q  <= hit || tag_i.stop || tag_i.last_key;
      found_q <= hit ? tag_i.key : 128'd0;
      tried_q <= tried_d;
    end
  end

  assign vld_o        = vld_q;
  assign match_o      = match_q;
  assign done_res_o   = done_q;
  assign found_key_o  = found_q;
  assign key_count_o  = tried_q;

  `ASSERT_IMPL(a_match_done, clk_i, rst_ni, vld_q && match_q |-> done_q)
  `ASSERT_IMPL(a_cnt_clear, clk_i, rst_ni, $past(load) && done_q |-> cnt_q == 64'd0)
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, !adv_i && !take_i |=> $stable(cnt_q))
endmodule
`default_nettype wire

>>> hdl/aes128_known_plaintext_key_search_core.sv
// Top level of the AES-128 known-plaintext key search core.
// Depends on aesks_pkg, aesks_round, aesks_tally, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// One candidate key per item, one result item per key, in order. The block
// is a 12-stage pipeline: an input stage (initial AddRoundKey), ten round
// stages each doing one AES round and one key schedule step, and a compare
// stage that also keeps the saturating tested-key counter and holds the
// result. Throughput is one key per cycle while the output is not stalled. A
// stall on the output freezes the whole pipeline:
// in_stall_o is high exactly when a result sits in the output register and
// out_stall_i is high, and then new keys are held off even if bubbles remain
// upstream. A stop item skips the test and reports the count before it.
// Configuration must be written only while the pipeline is empty.
module aes128_known_plaintext_key_search_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  input  wire logic        last_key_i,
  input  wire logic        stop_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             match_o,
  output logic             done_res_o,
  output logic [63:0]      found_key_hi_o,
  output logic [63:0]      found_key_lo_o,
  output logic [63:0]      key_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  logic [63:0] pt_hi_q, pt_lo_q, tg_hi_q, tg_lo_q;
  logic        adv, take;

  // pipeline moves when the output slot is free or being taken
  assign take = out_valid_o && !out_stall_i;
  assign adv  = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_hi_q <= '0;
      pt_lo_q <= '0;
      tg_hi_q <= '0;
      tg_lo_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        aesks_pkg::RegPtHi: pt_hi_q <= cfg_data_i;
        aesks_pkg::RegPtLo: pt_lo_q <= cfg_data_i;
        aesks_pkg::RegTgHi: tg_hi_q <= cfg_data_i;
        aesks_pkg::RegTgLo: tg_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage: whitening with the raw key
  logic            v0_q;
  aesks_pkg::blk_t s0_q, k0_q;
  aesks_pkg::tag_t t0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= {pt_hi_q, pt_lo_q} ^ {key_hi_i, key_lo_i};
      k0_q <= {key_hi_i, key_lo_i};
      t0_q <= '{stop: stop_i, last_key: last_key_i, key: {key_hi_i, key_lo_i}};
    end
  end

  logic            vp [aesks_pkg::NumRounds+1];
  aesks_pkg::blk_t sp [aesks_pkg::NumRounds+1];
  aesks_pkg::blk_t kp [aesks_pkg::NumRounds+1];
  aesks_pkg::tag_t tp [aesks_pkg::NumRounds+1];

  assign vp[0] = v0_q;
  assign sp[0] = s0_q;
  assign kp[0] = k0_q;
  assign tp[0] = t0_q;

  for (genvar r = 0; r < aesks_pkg::NumRounds; r++) begin : g_rnd
    aesks_round u_rnd (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .rcon_i (aesks_pkg::RCON[r]),
      .mix_i  (r != aesks_pkg::NumRounds - 1),
      .vld_i  (vp[r]),
      .st_i   (sp[r]),
      .rk_i   (kp[r]),
      .tag_i  (tp[r]),
      .vld_o  (vp[r+1]),
      .st_o   (sp[r+1]),
      .rk_o   (kp[r+1]),
      .tag_o  (tp[r+1])
    );
  end

  logic [127:0] found;

  aesks_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .take_i       (take),
    .vld_i        (vp[aesks_pkg::NumRounds]),
    .ct_i         (sp[aesks_pkg::NumRounds]),
    .target_i     ({tg_hi_q, tg_lo_q}),
    .tag_i        (tp[aesks_pkg::NumRounds]),
    .vld_o        (out_valid_o),
    .match_o      (match_o),
    .done_res_o   (done_res_o),
    .found_key_o  (found),
    .key_count_o  (key_count_o)
  );

  assign found_key_hi_o = found[127:64];
  assign found_key_lo_o = found[63:0];

  `ASSERT_IMPL(a_stall_full, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  `ASSERT_IMPL(a_found_zero, clk_i, rst_ni, out_valid_o && !match_o |-> found == 128'd0)
  `ASSERT_IMPL(a_frozen, clk_i, rst_ni, in_stall_o |=> $stable(vp[aesks_pkg::NumRounds]))
endmodule
`default_nettype wire
